FILE: hdl/pba2x2_pkg.sv
// shared constants and types for the 2x2 block-average pixelator
package pba2x2_pkg;

  localparam int PIXEL_W = 8;
  localparam int SUM_W = 9;
  localparam int COORD_W = 9;
  localparam int CFG_W = 10;

  localparam int DEF_MAX_WIDTH = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 10'd512;
  localparam logic [CFG_W-1:0] CFG_SIZE_MIN = 10'd2;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    PH_TOP_LEFT,
    PH_TOP_RIGHT,
    PH_BOT_LEFT,
    PH_BOT_RIGHT
  } phase_t;

endpackage

FILE: hdl/pba2x2_in_if.sv
// pixel input channel
interface pba2x2_in_if;
  logic                               valid;
  logic                               ready;
  logic [pba2x2_pkg::PIXEL_W-1:0]     pixel_value;
  logic                               frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

FILE: hdl/pba2x2_out_if.sv
// block-average result channel
interface pba2x2_out_if;
  logic                               valid;
  logic                               ready;
  logic [pba2x2_pkg::COORD_W-1:0]     out_row;
  logic [pba2x2_pkg::COORD_W-1:0]     out_col;
  logic [pba2x2_pkg::PIXEL_W-1:0]     out_value;
  logic                               block_last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output block_last, input ready);
  modport sink (input valid, input out_row, input out_col, input out_value,
                input block_last, output ready);
endinterface

FILE: hdl/pba2x2_line_store.sv
// half-row line store of even-row pair sums, registered read
module pba2x2_line_store #(
  parameter int MAX_WIDTH = pba2x2_pkg::DEF_MAX_WIDTH,
  localparam int DEPTH = (MAX_WIDTH + 1) / 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 addr,
  input  logic [pba2x2_pkg::SUM_W-1:0]  wdata,
  output logic [pba2x2_pkg::SUM_W-1:0]  rdata
);

  logic [pba2x2_pkg::SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hdl/pixelate_block_average_2x2.sv
// top level: 2x2 block-average pixelator with line store and result burst
// a completed block passes stage one, then the burst register, which offers its words
// throughput: one pixel per cycle on even rows while stage one is free; on odd rows the
//   pixel rate is bounded by the four-word result burst of each completed block
// reset: counters, pair sum and size registers (512) are set; the line store is not
//   cleared, an even row always writes an entry before the odd row reads it
module pixelate_block_average_2x2 #(
  parameter int MAX_WIDTH = pba2x2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pba2x2_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  pba2x2_in_if.sink                          pixels,
  pba2x2_out_if.source                       results,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pba2x2_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pba2x2_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pba2x2_pkg::APB_DATA_W-1:0]  prdata,
  output logic                               pready
);

  localparam int CFG_W = pba2x2_pkg::CFG_W;
  localparam int COORD_W = pba2x2_pkg::COORD_W;
  localparam int SUM_W = pba2x2_pkg::SUM_W;
  localparam int PIXEL_W = pba2x2_pkg::PIXEL_W;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int CRW = (CW > RW) ? CW : RW;
  localparam int SW = (CRW + 1 > CFG_W) ? CRW + 1 : CFG_W;
  localparam int XW = (CRW > COORD_W) ? CRW : COORD_W;
  localparam int DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= pba2x2_pkg::CFG_SIZE_RESET;
      image_height <= pba2x2_pkg::CFG_SIZE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pba2x2_pkg::REG_IMAGE_WIDTH:  image_width <= pwdata[CFG_W-1:0];
        pba2x2_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pba2x2_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, image_width};
      pba2x2_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, image_height};
      default:                      prdata = '0;
    endcase
  end

  // clamped sizes
  logic [SW-1:0] w_use;
  logic [SW-1:0] h_use;

  always_comb begin
    w_use = SW'(image_width);
    if (image_width < pba2x2_pkg::CFG_SIZE_MIN) begin
      w_use = SW'(pba2x2_pkg::CFG_SIZE_MIN);
    end else if (w_use > SW'(MAX_WIDTH)) begin
      w_use = SW'(MAX_WIDTH);
    end
    h_use = SW'(image_height);
    if (image_height < pba2x2_pkg::CFG_SIZE_MIN) begin
      h_use = SW'(pba2x2_pkg::CFG_SIZE_MIN);
    end else if (h_use > SW'(MAX_HEIGHT)) begin
      h_use = SW'(MAX_HEIGHT);
    end
  end

  // raster position of the incoming pixel
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;
  logic [SUM_W-1:0] pair_sum;
  logic [SW-1:0]    cur_col;
  logic [SW-1:0]    cur_row;
  logic [SW-1:0]    col_inc;
  logic [SW-1:0]    row_inc;
  logic [CW-1:0]    column_count_next;
  logic [RW-1:0]    row_count_next;
  logic [SUM_W-1:0] pair_sum_next;

  always_comb begin
    cur_col = pixels.frame_start ? '0 : SW'(column_count);
    cur_row = pixels.frame_start ? '0 : SW'(row_count);
    if (cur_col >= w_use) begin
      cur_col = '0;
      cur_row = cur_row + SW'(1);
    end
    if (cur_row >= h_use) begin
      cur_row = '0;
    end
    col_inc = cur_col + SW'(1);
    row_inc = cur_row + SW'(1);
    if (col_inc >= w_use) begin
      column_count_next = '0;
      row_count_next = (row_inc >= h_use) ? '0 : RW'(row_inc);
    end else begin
      column_count_next = CW'(col_inc);
      row_count_next = RW'(cur_row);
    end
    pair_sum_next = cur_col[0] ? pair_sum + SUM_W'(pixels.pixel_value)
                               : SUM_W'(pixels.pixel_value);
  end

  logic in_fire;
  logic st_wr;
  logic st_rd;
  logic [AW-1:0] st_addr;
  logic [SUM_W-1:0] st_rdata;

  assign in_fire = pixels.valid && pixels.ready;
  assign st_wr = in_fire && cur_col[0] && !cur_row[0];
  assign st_rd = in_fire && cur_col[0] && cur_row[0];
  assign st_addr = cur_col[AW:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      pair_sum <= '0;
    end else if (in_fire) begin
      column_count <= column_count_next;
      row_count <= row_count_next;
      pair_sum <= pair_sum_next;
    end
  end

  pba2x2_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .wr_en (st_wr),
    .rd_en (st_rd),
    .addr  (st_addr),
    .wdata (pair_sum_next),
    .rdata (st_rdata)
  );

  // stage one: completed block held with its line store word until the burst register takes it
  logic             s1_valid;
  logic [XW-1:0]    s1_row;
  logic [XW-1:0]    s1_col;
  logic [SUM_W-1:0] s1_pair;
  logic             s1_move;

  // result burst register
  logic                 blk_valid;
  pba2x2_pkg::phase_t   blk_phase;
  pba2x2_pkg::phase_t   blk_phase_next;
  logic [XW-1:0]        blk_row;
  logic [XW-1:0]        blk_col;
  logic [PIXEL_W-1:0]   blk_avg;
  logic                 out_fire;
  logic                 blk_done;
  logic [SUM_W:0]       block_sum;
  logic [XW-1:0]        row_m1;
  logic [XW-1:0]        col_m1;

  assign out_fire = blk_valid && results.ready;
  assign blk_done = out_fire && (blk_phase == pba2x2_pkg::PH_BOT_RIGHT);
  assign s1_move = s1_valid && (!blk_valid || blk_done);
  assign pixels.ready = !s1_valid || s1_move;
  assign block_sum = (SUM_W+1)'(st_rdata) + (SUM_W+1)'(s1_pair);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (st_rd) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_rd) begin
      s1_row <= XW'(cur_row);
      s1_col <= XW'(cur_col);
      s1_pair <= pair_sum_next;
    end
  end

  always_comb begin
    unique case (blk_phase)
      pba2x2_pkg::PH_TOP_LEFT:  blk_phase_next = pba2x2_pkg::PH_TOP_RIGHT;
      pba2x2_pkg::PH_TOP_RIGHT: blk_phase_next = pba2x2_pkg::PH_BOT_LEFT;
      pba2x2_pkg::PH_BOT_LEFT:  blk_phase_next = pba2x2_pkg::PH_BOT_RIGHT;
      pba2x2_pkg::PH_BOT_RIGHT: blk_phase_next = pba2x2_pkg::PH_TOP_LEFT;
      default:                  blk_phase_next = pba2x2_pkg::PH_TOP_LEFT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      blk_phase <= pba2x2_pkg::PH_TOP_LEFT;
    end else if (s1_move) begin
      blk_valid <= 1'b1;
      blk_phase <= pba2x2_pkg::PH_TOP_LEFT;
    end else if (blk_done) begin
      blk_valid <= 1'b0;
      blk_phase <= pba2x2_pkg::PH_TOP_LEFT;
    end else if (out_fire) begin
      blk_phase <= blk_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      blk_row <= s1_row;
      blk_col <= s1_col;
      blk_avg <= block_sum[SUM_W:2];
    end
  end

  assign row_m1 = blk_row - XW'(1);
  assign col_m1 = blk_col - XW'(1);

  always_comb begin
    results.valid = blk_valid;
    results.out_value = blk_avg;
    results.block_last = (blk_phase == pba2x2_pkg::PH_BOT_RIGHT);
    if (blk_phase == pba2x2_pkg::PH_BOT_LEFT || blk_phase == pba2x2_pkg::PH_BOT_RIGHT) begin
      results.out_row = blk_row[COORD_W-1:0];
    end else begin
      results.out_row = row_m1[COORD_W-1:0];
    end
    if (blk_phase == pba2x2_pkg::PH_TOP_RIGHT || blk_phase == pba2x2_pkg::PH_BOT_RIGHT) begin
      results.out_col = blk_col[COORD_W-1:0];
    end else begin
      results.out_col = col_m1[COORD_W-1:0];
    end
  end

endmodule

FILE: hdl/pba2x2_checker.sv
// port-level assertions for the pixelator, bound to the top level
module pba2x2_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [pba2x2_pkg::COORD_W-1:0]    out_row,
  input logic [pba2x2_pkg::COORD_W-1:0]    out_col,
  input logic [pba2x2_pkg::PIXEL_W-1:0]    out_value,
  input logic                              block_last
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_row) && $stable(out_col)
                                   && $stable(out_value) && $stable(block_last)))
    else $error("stalled result word changed");

  // a block burst continues until its last word
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !block_last) |=> out_valid)
    else $error("block burst broken before last word");

  // same average across a burst
  a_burst_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !block_last) |=> $stable(out_value))
    else $error("average changed within a block");

  // the last word sits at odd row and odd column
  a_last_odd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_last) |-> (out_row[0] && out_col[0]))
    else $error("last word of block at even coordinate");

endmodule

bind pixelate_block_average_2x2 pba2x2_checker u_pba2x2_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_row    (results.out_row),
  .out_col    (results.out_col),
  .out_value  (results.out_value),
  .block_last (results.block_last)
);
